// ----- sv/bss_pkg.sv -----
`timescale 1ns / 1ps

package bss_pkg;

  localparam int unsigned QuotW = 21;
  localparam int unsigned FracW = 16;
  localparam int unsigned TermW = 17;

  localparam logic [16:0] TermOne = 17'd65536;
  localparam logic [15:0] TauFallback = 16'd1920;
  localparam logic [24:0] Log2eQ24 = 25'd24204406;

  localparam logic [2:0] RegWeightRecency = 3'd0;
  localparam logic [2:0] RegWeightSignal = 3'd1;
  localparam logic [2:0] RegWeightRandom = 3'd2;
  localparam logic [2:0] RegWeightClass = 3'd3;
  localparam logic [2:0] RegWeightCrowding = 3'd4;
  localparam logic [2:0] RegRecencyTau = 3'd5;

  localparam logic [2:0] ClsTentative = 3'd0;
  localparam logic [2:0] ClsStaticRandom = 3'd1;
  localparam logic [2:0] ClsNrpa = 3'd2;
  localparam logic [2:0] ClsRpa = 3'd3;
  localparam logic [2:0] ClsPublic = 3'd4;
  localparam logic [2:0] ClsWifi = 3'd5;

  typedef struct packed {
    logic [16:0] signal_term;
    logic [16:0] class_term;
    logic [16:0] crowd_term;
    logic [15:0] random_term;
  } side_t;

  typedef struct packed {
    logic [15:0] w_recency;
    logic [15:0] w_signal;
    logic [15:0] w_random;
    logic [15:0] w_class;
    logic [15:0] w_crowding;
  } weights_t;

  typedef struct packed {
    logic [15:0]      rem;
    logic [QuotW-1:0] quo;
  } div_t;

  // Q24 values of 2^-(2^-(i+1)), indexed from the top fraction bit down.
  function automatic logic [23:0] exp2_neg_frac(input logic [3:0] idx);
    logic [23:0] c;
    case (idx)
      4'd0:    c = 24'd11863283;
      4'd1:    c = 24'd14107901;
      4'd2:    c = 24'd15384775;
      4'd3:    c = 24'd16065917;
      4'd4:    c = 24'd16417715;
      4'd5:    c = 24'd16596492;
      4'd6:    c = 24'd16686609;
      4'd7:    c = 24'd16731851;
      4'd8:    c = 24'd16754518;
      4'd9:    c = 24'd16765863;
      4'd10:   c = 24'd16771539;
      4'd11:   c = 24'd16774377;
      4'd12:   c = 24'd16775796;
      4'd13:   c = 24'd16776506;
      4'd14:   c = 24'd16776861;
      default: c = 24'd16777039;
    endcase
    return c;
  endfunction

  // Unknown classes take the 0.3 prior.
  function automatic logic [16:0] class_prior(input logic [2:0] cls);
    logic [16:0] p;
    case (cls)
      ClsTentative:    p = 17'd19661;
      ClsStaticRandom: p = 17'd65536;
      ClsNrpa:         p = 17'd45875;
      ClsRpa:          p = 17'd16384;
      ClsPublic:       p = 17'd45875;
      ClsWifi:         p = 17'd52429;
      default:         p = 17'd19661;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/bss_div.sv -----
`timescale 1ns / 1ps

module bss_div #(
  parameter int unsigned BitsPerStage = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [23:0]                age_i,
  input  logic [15:0]                tau_i,
  input  bss_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic                       big_o,
  output logic [bss_pkg::QuotW-1:0]  quot_o,
  output bss_pkg::side_t             side_o
);
  import bss_pkg::*;

  localparam int unsigned Stages = (QuotW + BitsPerStage - 1) / BitsPerStage;

  function automatic div_t div_step(input div_t cur, input logic [15:0] tau);
    logic [16:0] trial;
    div_t        nxt;
    trial = {cur.rem, cur.quo[QuotW-1]};
    nxt.quo = {cur.quo[QuotW-2:0], 1'b0};
    if (trial >= {1'b0, tau}) begin
      nxt.rem = 16'(trial - {1'b0, tau});
      nxt.quo[0] = 1'b1;
    end else begin
      nxt.rem = trial[15:0];
    end
    return nxt;
  endfunction

  logic  valid_q [Stages];
  logic  big_q   [Stages];
  div_t  div_q   [Stages];
  side_t side_q  [Stages];

  div_t init_div;
  logic init_big;

  // The quotient is only needed below 2^21; anything larger gives zero recency.
  assign init_div.rem = {1'b0, age_i[23:9]};
  assign init_div.quo = {age_i[8:0], 12'd0};
  assign init_big = ({1'b0, age_i[23:9]} >= tau_i);

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic  in_valid;
    logic  in_big;
    div_t  in_div;
    side_t in_side;
    div_t  out_div;

    if (s == 0) begin : g_first
      assign in_valid = valid_i;
      assign in_big = init_big;
      assign in_div = init_div;
      assign in_side = side_i;
    end else begin : g_next
      assign in_valid = valid_q[s-1];
      assign in_big = big_q[s-1];
      assign in_div = div_q[s-1];
      assign in_side = side_q[s-1];
    end

    always_comb begin
      out_div = in_div;
      for (int j = 0; j < BitsPerStage; j++) begin
        if (s * BitsPerStage + j < QuotW) begin
          out_div = div_step(out_div, tau_i);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        big_q[s] <= in_big;
        div_q[s] <= out_div;
        side_q[s] <= in_side;
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign big_o = big_q[Stages-1];
  assign quot_o = div_q[Stages-1].quo;
  assign side_o = side_q[Stages-1];

endmodule

// ----- sv/bss_exp.sv -----
`timescale 1ns / 1ps

module bss_exp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic                      big_i,
  input  logic [bss_pkg::QuotW-1:0] x_i,
  input  bss_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [16:0]               recency_o,
  output bss_pkg::side_t            side_o
);
  import bss_pkg::*;

  localparam logic [45:0] HalfY = 46'd8388608;
  localparam logic [48:0] HalfP = 49'd8388608;

  logic [45:0] y_prod;
  logic [21:0] y_val;

  assign y_prod = 46'(x_i) * 46'(Log2eQ24) + HalfY;
  assign y_val = y_prod[45:24];

  logic        yv_q;
  logic        yzero_q;
  logic [4:0]  yk_q;
  logic [15:0] yf_q;
  side_t       yside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yv_q <= 1'b0;
    end else if (en_i) begin
      yv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yzero_q <= big_i || (y_val[21:16] >= 6'd17);
      yk_q <= y_val[20:16];
      yf_q <= y_val[15:0];
      yside_q <= side_i;
    end
  end

  logic        valid_q [FracW];
  logic        zero_q  [FracW];
  logic [4:0]  k_q     [FracW];
  logic [15:0] f_q     [FracW];
  logic [24:0] p_q     [FracW];
  side_t       side_q  [FracW];

  for (genvar i = 0; i < FracW; i++) begin : g_bit
    logic        in_valid;
    logic        in_zero;
    logic [4:0]  in_k;
    logic [15:0] in_f;
    logic [24:0] in_p;
    side_t       in_side;
    logic [48:0] mult;

    if (i == 0) begin : g_first
      assign in_valid = yv_q;
      assign in_zero = yzero_q;
      assign in_k = yk_q;
      assign in_f = yf_q;
      assign in_p = 25'd16777216;
      assign in_side = yside_q;
    end else begin : g_next
      assign in_valid = valid_q[i-1];
      assign in_zero = zero_q[i-1];
      assign in_k = k_q[i-1];
      assign in_f = f_q[i-1];
      assign in_p = p_q[i-1];
      assign in_side = side_q[i-1];
    end

    assign mult = 49'(in_p) * 49'(exp2_neg_frac(4'(i))) + HalfP;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i] <= in_zero;
        k_q[i] <= in_k;
        f_q[i] <= in_f;
        p_q[i] <= in_f[FracW-1-i] ? mult[48:24] : in_p;
        side_q[i] <= in_side;
      end
    end
  end

  logic [24:0] shifted;
  logic [25:0] rounded;
  logic        out_valid_q;
  logic [16:0] recency_q;
  side_t       out_side_q;

  // Shift by k+8 with round half up, done as a shift by k+7 and a rounding halving.
  assign shifted = p_q[FracW-1] >> (k_q[FracW-1] + 5'd7);
  assign rounded = 26'(shifted) + 26'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= valid_q[FracW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      recency_q <= zero_q[FracW-1] ? 17'd0 : rounded[17:1];
      out_side_q <= side_q[FracW-1];
    end
  end

  assign valid_o = out_valid_q;
  assign recency_o = recency_q;
  assign side_o = out_side_q;

endmodule

// ----- sv/bss_score.sv -----
`timescale 1ns / 1ps

module bss_score (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [16:0]       recency_i,
  input  bss_pkg::side_t    side_i,
  input  bss_pkg::weights_t weights_i,
  output logic              valid_o,
  output logic [18:0]       score_o
);
  import bss_pkg::*;

  localparam logic signed [19:0] ScoreMax = 20'sd262143;
  localparam logic signed [19:0] ScoreMin = -20'sd262144;

  logic        mv_q;
  logic [32:0] p_rec_q;
  logic [32:0] p_sig_q;
  logic [32:0] p_rnd_q;
  logic [32:0] p_cls_q;
  logic [32:0] p_crd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en_i) begin
      mv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rec_q <= 33'(weights_i.w_recency) * 33'(recency_i);
      p_sig_q <= 33'(weights_i.w_signal) * 33'(side_i.signal_term);
      p_rnd_q <= 33'(weights_i.w_random) * 33'(side_i.random_term);
      p_cls_q <= 33'(weights_i.w_class) * 33'(side_i.class_term);
      p_crd_q <= 33'(weights_i.w_crowding) * 33'(side_i.crowd_term);
    end
  end

  logic [34:0]        pos_sum;
  logic signed [36:0] acc;
  logic signed [19:0] scaled;
  logic [18:0]        score_d;
  logic               sv_q;
  logic [18:0]        score_q;

  assign pos_sum = 35'(p_rec_q) + 35'(p_sig_q) + 35'(p_rnd_q) + 35'(p_cls_q);
  assign acc = $signed({2'b00, pos_sum}) - $signed({4'b0000, p_crd_q}) + 37'sd65536;
  assign scaled = 20'(acc >>> 17);

  always_comb begin
    if (scaled > ScoreMax) begin
      score_d = ScoreMax[18:0];
    end else if (scaled < ScoreMin) begin
      score_d = ScoreMin[18:0];
    end else begin
      score_d = scaled[18:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else if (en_i) begin
      sv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      score_q <= score_d;
    end
  end

  assign valid_o = sv_q;
  assign score_o = score_q;

endmodule

// ----- sv/beacon_subset_score.sv -----
`timescale 1ns / 1ps

// Channel      Direction  Payload
// s_axis       in         tdata: age, signal, crowding, random; tuser: class
// m_axis       out        tdata: selection score (signed Q4.15)
// cfg          in         register index and 16-bit value
//
// One candidate is accepted per cycle while the output is not stalled; each score
// passes through one input register, ceil(21/BitsPerStage) divider stages, one
// log2 scale stage, sixteen exp2 stages, one shift stage, one multiply stage and
// the output register.
// Reset clears all valid bits and loads the register defaults.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.

module beacon_subset_score #(
  parameter int unsigned BitsPerStage = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // age_seconds, signal_dbm, crowding_level, random_unit
  input  logic [2:0]  s_axis_tuser,  // beacon_class
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // selection_score, zero padded
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bss_pkg::*;

  logic en;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o = 1'b1;

  weights_t    weights_q;
  logic [15:0] tau_q;
  logic [15:0] tau_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q.w_recency <= 16'd9830;
      weights_q.w_signal <= 16'd4915;
      weights_q.w_random <= 16'd8192;
      weights_q.w_class <= 16'd11469;
      weights_q.w_crowding <= 16'd6554;
      tau_q <= TauFallback;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWeightRecency:  weights_q.w_recency <= cfg_data_i;
        RegWeightSignal:   weights_q.w_signal <= cfg_data_i;
        RegWeightRandom:   weights_q.w_random <= cfg_data_i;
        RegWeightClass:    weights_q.w_class <= cfg_data_i;
        RegWeightCrowding: weights_q.w_crowding <= cfg_data_i;
        RegRecencyTau:     tau_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tau_eff = (tau_q == 16'd0) ? TauFallback : tau_q;

  logic        in_valid_q;
  logic [23:0] age_q;
  logic [7:0]  dbm_q;
  logic [2:0]  cls_q;
  logic [15:0] crowd_q;
  logic [15:0] rnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s_axis_tvalid) begin
      age_q <= s_axis_tdata[23:0];
      dbm_q <= s_axis_tdata[31:24];
      crowd_q <= s_axis_tdata[47:32];
      rnd_q <= s_axis_tdata[63:48];
      cls_q <= s_axis_tuser;
    end
  end

  logic signed [8:0] sig_s;
  logic [21:0]       sig_num;
  logic [44:0]       sig_prod;
  logic [16:0]       sig_term;
  logic [16:0]       crowd_term;
  side_t             side_in;

  // Division by 50 through a reciprocal; exact for every numerator below 2^22.
  assign sig_s = 9'(signed'(dbm_q)) + 9'sd95;
  assign sig_num = {sig_s[5:0], 16'd0} + 22'd25;
  assign sig_prod = 45'(sig_num) * 45'd5368710;

  always_comb begin
    if (sig_s <= 9'sd0) begin
      sig_term = 17'd0;
    end else if (sig_s >= 9'sd50) begin
      sig_term = TermOne;
    end else begin
      sig_term = sig_prod[44:28];
    end
  end

  always_comb begin
    if (crowd_q[15]) begin
      crowd_term = 17'd0;
    end else if (crowd_q > 16'd16384) begin
      crowd_term = TermOne;
    end else begin
      crowd_term = {crowd_q[14:0], 2'b00};
    end
  end

  assign side_in.signal_term = sig_term;
  assign side_in.class_term = class_prior(cls_q);
  assign side_in.crowd_term = crowd_term;
  assign side_in.random_term = rnd_q;

  logic             div_valid;
  logic             div_big;
  logic [QuotW-1:0] div_quot;
  side_t            div_side;

  bss_div #(
    .BitsPerStage(BitsPerStage)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_q),
    .age_i   (age_q),
    .tau_i   (tau_eff),
    .side_i  (side_in),
    .valid_o (div_valid),
    .big_o   (div_big),
    .quot_o  (div_quot),
    .side_o  (div_side)
  );

  logic        exp_valid;
  logic [16:0] exp_recency;
  side_t       exp_side;

  bss_exp u_exp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (div_valid),
    .big_i     (div_big),
    .x_i       (div_quot),
    .side_i    (div_side),
    .valid_o   (exp_valid),
    .recency_o (exp_recency),
    .side_o    (exp_side)
  );

  logic [18:0] score;

  bss_score u_score (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (exp_valid),
    .recency_i (exp_recency),
    .side_i    (exp_side),
    .weights_i (weights_q),
    .valid_o   (m_axis_tvalid),
    .score_o   (score)
  );

  assign m_axis_tdata = {5'd0, score};

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  a_recency_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_valid |-> (exp_recency <= TermOne))
    else $error("recency term above one");

  a_signal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> (sig_term <= TermOne))
    else $error("signal term above one");

endmodule

// ----- bench/beacon_subset_score_tb.sv -----
`timescale 1ns / 1ps

module beacon_subset_score_tb;
  import bss_pkg::*;

  typedef struct packed {
    logic [15:0]        rnd;
    logic signed [15:0] crowd;
    logic signed [7:0]  dbm;
    logic [23:0]        age;
  } sighting_t;

  typedef struct packed {
    sighting_t   s;
    logic [2:0]  cls;
    logic        known;
    logic [18:0] score;
  } probe_t;

  typedef struct packed {
    logic        known;
    logic [18:0] score;
  } pin_t;

  typedef enum int {FlowFree, FlowSrcGaps, FlowSinkStalls, FlowBoth} flow_e;

  localparam logic [2:0] ClsUnknownLo = 3'd6;
  localparam logic [2:0] ClsUnknownHi = 3'd7;
  localparam logic [2:0] UnusedRegLo = 3'd6;
  localparam logic [2:0] UnusedRegHi = 3'd7;
  localparam int ResultLatency = 27;
  localparam int MaxReports = 10;
  localparam int NoPause = -1;

  // Q24 factors 2^-(2^-(i+1)), entry i at bits [24*i +: 24].
  localparam logic [16*24-1:0] HalvingQ24 = {
    24'd16777039, 24'd16776861, 24'd16776506, 24'd16775796,
    24'd16774377, 24'd16771539, 24'd16765863, 24'd16754518,
    24'd16731851, 24'd16686609, 24'd16596492, 24'd16417715,
    24'd16065917, 24'd15384775, 24'd14107901, 24'd11863283
  };

  // Class priors in Q16, entry c at bits [17*c +: 17]; unknown classes get 0.3.
  localparam logic [8*17-1:0] PriorQ16 = {
    17'd19661, 17'd19661, 17'd52429, 17'd45875,
    17'd16384, 17'd45875, 17'd65536, 17'd19661
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  logic [15:0] w_recency = 16'd9830;
  logic [15:0] w_signal = 16'd4915;
  logic [15:0] w_random = 16'd8192;
  logic [15:0] w_class = 16'd11469;
  logic [15:0] w_crowding = 16'd6554;
  logic [15:0] tau_q4 = 16'd1920;

  logic [18:0] expected_scores[$];
  pin_t        pin_q[$];
  probe_t      probes[$];
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int          long_hold = 0;
  int          mismatches = 0;

  beacon_subset_score u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [16:0] recency_q16(input logic [23:0] age, input logic [15:0] tau);
    logic [63:0] div, ratio, log2_q16, whole, frac, mant;
    int i;
    div = (tau == '0) ? 64'(TauFallback) : 64'(tau);
    ratio = (64'(age) << 12) / div;
    log2_q16 = (ratio * 64'(Log2eQ24) + 64'd8388608) >> 24;
    whole = log2_q16 >> 16;
    frac = log2_q16 & 64'hFFFF;
    if (whole >= 64'd17) return '0;
    mant = 64'd1 << 24;
    for (i = 0; i < 16; i++) begin
      if (frac[15-i]) mant = (mant * 64'(HalvingQ24[i*24 +: 24]) + 64'd8388608) >> 24;
    end
    return 17'((mant + (64'd1 << (whole + 64'd7))) >> (whole + 64'd8));
  endfunction

  function automatic logic [16:0] rssi_q16(input logic signed [7:0] dbm);
    int lift;
    lift = int'(dbm) + 95;
    if (lift <= 0) return '0;
    if (lift >= 50) return 17'd65536;
    return 17'((lift * 65536 + 25) / 50);
  endfunction

  function automatic logic [18:0] score_of(input sighting_t s, input logic [2:0] cls);
    longint crowd, acc, q;
    crowd = longint'($signed(s.crowd));
    if (crowd < 0) crowd = 0;
    if (crowd > 16384) crowd = 16384;
    acc = longint'(w_recency) * longint'(recency_q16(s.age, tau_q4))
        + longint'(w_signal) * longint'(rssi_q16(s.dbm))
        + longint'(w_random) * longint'(s.rnd)
        + longint'(w_class) * longint'(PriorQ16[cls*17 +: 17])
        - longint'(w_crowding) * (crowd << 2);
    q = ((acc + (longint'(1) << 33) + (longint'(1) << 16)) >>> 17) - (longint'(1) << 16);
    if (q > 262143) q = 262143;
    if (q < -262144) q = -262144;
    return q[18:0];
  endfunction

  function automatic void flag_score(input string what, input logic [18:0] want,
                                     input logic [18:0] got);
    if (mismatches < MaxReports)
      $display("%0t: %s: expected %0d, got %0d", $time, what, $signed(want), $signed(got));
    mismatches++;
  endfunction

  always @(posedge clk_i) begin : track
    pin_t pin;
    logic [18:0] got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegWeightRecency:  w_recency = cfg_data_i;
          RegWeightSignal:   w_signal = cfg_data_i;
          RegWeightRandom:   w_random = cfg_data_i;
          RegWeightClass:    w_class = cfg_data_i;
          RegWeightCrowding: w_crowding = cfg_data_i;
          RegRecencyTau:     tau_q4 = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
        expected_scores.push_back(pin.known ? pin.score : score_of(s_axis_tdata, s_axis_tuser));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[18:0];
        if (expected_scores.size() == 0) begin
          flag_score("score with none pending", 'x, got);
        end else begin
          if (got !== expected_scores[0]) flag_score("selection_score", expected_scores[0], got);
          void'(expected_scores.pop_front());
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold > 0) begin
        m_axis_tready <= 1'b0;
        long_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic probe_t probe(input int age, input int dbm, input logic [2:0] cls,
                                   input int crowd, input int rnd, input logic known,
                                   input int score);
    probe_t p;
    p.s.age = 24'(age);
    p.s.dbm = 8'(dbm);
    p.s.crowd = 16'(crowd);
    p.s.rnd = 16'(rnd);
    p.cls = cls;
    p.known = known;
    p.score = 19'(score);
    return p;
  endfunction

  function automatic sighting_t random_sighting();
    sighting_t s;
    case ($urandom_range(3))
      0:       s.age = 24'($urandom);
      1:       s.age = 24'($urandom_range(32'h8_0000));
      2:       s.age = 24'($urandom_range(32'h400));
      default: s.age = $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
    endcase
    s.dbm = $urandom_range(1) ? 8'($urandom) : 8'(int'($urandom_range(70)) - 110);
    s.crowd = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(17000));
    s.rnd = 16'($urandom);
    return s;
  endfunction

  task automatic offer(input sighting_t s, input logic [2:0] cls, input logic known,
                       input logic [18:0] score);
    pin_t pin;
    pin.known = known;
    pin.score = score;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    pin_q.push_back(pin);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    s_axis_tuser <= cls;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_scores.size() != 0);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic run_phase(input logic [15:0] wr, input logic [15:0] ws, input logic [15:0] wn,
                           input logic [15:0] wc, input logic [15:0] wx, input logic [15:0] tau,
                           input flow_e flow, input int count, input int pause_at,
                           input int hold, input bit stray);
    int n;
    cfg_write(RegWeightRecency, wr);
    cfg_write(RegWeightSignal, ws);
    cfg_write(RegWeightRandom, wn);
    cfg_write(RegWeightClass, wc);
    cfg_write(RegWeightCrowding, wx);
    cfg_write(RegRecencyTau, tau);
    if (stray) begin
      cfg_write(UnusedRegLo, 16'($urandom));
      cfg_write(UnusedRegHi, 16'($urandom));
    end
    cfg_valid_i <= 1'b0;
    case (flow)
      FlowSrcGaps: begin
        src_idle_pct = 66;
        sink_stall_pct = 0;
      end
      FlowSinkStalls: begin
        src_idle_pct = 0;
        sink_stall_pct = 66;
      end
      FlowBoth: begin
        src_idle_pct = 30;
        sink_stall_pct = 30;
      end
      default: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
    endcase
    long_hold = hold;
    for (n = 0; n < count; n++) begin
      if (n == pause_at) drain();
      offer(random_sighting(), 3'($urandom), 1'b0, '0);
    end
    drain();
  endtask

  initial begin
    int p;
    probes = '{
      probe(16777215, -128, ClsStaticRandom,      0,     0, 1'b1, 5735),
      probe(       0,  -45, ClsStaticRandom,  16384,     0, 1'b1, 9830),
      probe(       0,  127, ClsStaticRandom,  32767,     0, 1'b1, 9830),
      probe(       0,  127, ClsStaticRandom, -32768, 65535, 1'b0, 0),
      probe(16777215,  -95, ClsRpa,           16384,     0, 1'b0, 0),
      probe(       1,  -94, ClsTentative,        -1,     1, 1'b0, 0),
      probe(     256,  -70, ClsNrpa,          16385, 32768, 1'b0, 0),
      probe(   30720,  -46, ClsPublic,         8192, 12345, 1'b0, 0),
      probe(  360448,  -60, ClsWifi,           4096, 65535, 1'b0, 0),
      probe(  362496,  -80, ClsUnknownLo,         0, 40000, 1'b0, 0),
      probe(  354304, -128, ClsUnknownHi,     16384,     0, 1'b0, 0),
      probe( 8388608,    0, ClsStaticRandom,      0, 65535, 1'b0, 0),
      probe(16777215,  127, ClsUnknownLo,    -32768, 65535, 1'b0, 0),
      probe(    4095, -100, ClsWifi,          20000,   777, 1'b0, 0),
      probe(   65536,  -96, ClsNrpa,              1, 65534, 1'b0, 0),
      probe(     100,  -45, ClsPublic,        16383, 32767, 1'b0, 0),
      probe(       0, -128, ClsTentative,         0,     0, 1'b0, 0)
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (probes[i]) offer(probes[i].s, probes[i].cls, probes[i].known, probes[i].score);
    drain();

    // The first phase holds the output off long enough to back the pipeline up.
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1,
              FlowFree, 240, NoPause, 300, 1'b0);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, FlowSrcGaps, 200, NoPause, 0, 1'b0);
    run_phase(16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'hFFFF,
              FlowSinkStalls, 240, NoPause, 0, 1'b0);
    run_phase(16'd9830, 16'd4915, 16'd8192, 16'd11469, 16'd6554, 16'd0,
              FlowBoth, 240, NoPause, 0, 1'b0);
    for (p = 0; p < 4; p++) begin
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom_range(4000)), flow_e'(p), 250, (p == 2) ? 120 : NoPause, 0,
                p == 0);
    end

    repeat (ResultLatency + 8) @(posedge clk_i);
    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("beacon_subset_score regression: pass");
    end else begin
      $display("beacon_subset_score regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("beacon_subset_score regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bss_pkg.sv
sv/bss_div.sv
sv/bss_exp.sv
sv/bss_score.sv
sv/beacon_subset_score.sv
bench/beacon_subset_score_tb.sv
